[rtl/max_flow_dfs_augment_defines.svh]
// assertion macros shared by the max flow block
// no dependencies; included by modules that carry assertions
`ifndef MAX_FLOW_DFS_AUGMENT_DEFINES_SVH
`define MAX_FLOW_DFS_AUGMENT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MFDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define MFDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mfda_pkg.sv]
// shared types and constants of the max flow block
// no dependencies
package mfda_pkg;

  // transaction operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // result width and saturation value
  localparam int         FLOW_W   = 20;
  localparam logic [FLOW_W-1:0] FLOW_MAX = 20'hFFFFF;

  // shared arithmetic unit operations
  typedef enum logic [1:0] {
    ALU_MIN,
    ALU_SUB,
    ALU_ADD
  } alu_op_t;

endpackage

[rtl/max_flow_dfs_augment.sv]
// max flow block top level: sequencer, matrix memories, search registers
// depends on mfda_pkg, mfda_alu and max_flow_dfs_augment_defines.svh
//
// Usage: transactions enter on in_valid/in_ready. A load writes one edge
// capacity, a clear zeroes the capacity matrix with a sweep of all
// 2**(2*clog2(MAX_VERTICES)) entries (256 by default), a run computes the
// maximum flow from source to sink and returns one result on out_valid /
// out_ready. Unknown operations are dropped.
// A run copies the capacity matrix into the residual matrix (one entry per
// cycle, 256 by default), then repeats a depth-first search: each neighbor
// probed passes a scan and a check state, each backtrack a scan and a pop
// state, all through one residual read port. For each path found the
// bottleneck minimum takes each edge through MINP, MINR and MINC, the update
// through UPDP, UPDR, UPDF and UPDB, and ACC adds the bottleneck to the total,
// all through the one shared arithmetic unit; in_ready is low throughout a run.
// After reset the capacity matrix is cleared by the same sweep, with
// in_ready low; cfg_wr_en writes are taken at any time.
// A finished result sits in the output register; a stalled receiver holds
// the block in its last run state, while loads wait behind it.
module max_flow_dfs_augment
  import mfda_pkg::*;
#(
  parameter int MAX_VERTICES = 16,
  parameter int CAP_WIDTH    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [3:0]  in_row_vertex,
  input  logic [3:0]  in_col_vertex,
  input  logic [15:0] in_edge_capacity,
  input  logic [3:0]  in_source_vertex,
  input  logic [3:0]  in_sink_vertex,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [19:0] out_max_flow
);

`include "max_flow_dfs_augment_defines.svh"

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int AW    = 2 * VW;
  localparam int DEPTH = 1 << AW;
  localparam int RW    = CAP_WIDTH + 1;
  localparam int FW    = CAP_WIDTH + VW + 1;
  localparam int TW    = (FW > FLOW_W) ? FW : FLOW_W;

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLR   = 4'd1;
  localparam logic [3:0] ST_COPY  = 4'd2;
  localparam logic [3:0] ST_SINIT = 4'd3;
  localparam logic [3:0] ST_SCAN  = 4'd4;
  localparam logic [3:0] ST_CHECK = 4'd5;
  localparam logic [3:0] ST_POP   = 4'd6;
  localparam logic [3:0] ST_MINP  = 4'd7;
  localparam logic [3:0] ST_MINR  = 4'd8;
  localparam logic [3:0] ST_MINC  = 4'd9;
  localparam logic [3:0] ST_UPDP  = 4'd10;
  localparam logic [3:0] ST_UPDR  = 4'd11;
  localparam logic [3:0] ST_UPDF  = 4'd12;
  localparam logic [3:0] ST_UPDB  = 4'd13;
  localparam logic [3:0] ST_ACC   = 4'd14;
  localparam logic [3:0] ST_FIN   = 4'd15;

  // control registers
  logic [3:0]              state_r, state_nxt;
  logic [4:0]              vcount_r;
  logic [AW:0]             cnt_r, cnt_nxt;
  logic                    cp_v_r, cp_v_nxt;
  logic [AW-1:0]           cp_a_r, cp_a_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // datapath registers
  logic [VW:0]             n_r, n_nxt;
  logic [VW-1:0]           s_r, s_nxt;
  logic [VW-1:0]           t_r, t_nxt;
  logic [VW-1:0]           u_r, u_nxt;
  logic [VW:0]             i_r, i_nxt;
  logic [VW-1:0]           v_r, v_nxt;
  logic [VW-1:0]           p_r, p_nxt;
  logic [FW-1:0]           least_r, least_nxt;
  logic [FW-1:0]           total_r, total_nxt;
  logic [FLOW_W-1:0]       out_flow_r, out_flow_nxt;

  // memories
  logic [CAP_WIDTH-1:0]    cap_mem [DEPTH];
  logic [RW-1:0]           res_mem [DEPTH];
  logic [VW-1:0]           par_mem [MAX_VERTICES];
  logic [CAP_WIDTH-1:0]    cap_q;
  logic [RW-1:0]           res_q;
  logic [VW-1:0]           par_q;

  logic                    cap_we;
  logic [AW-1:0]           cap_wa, cap_ra;
  logic [CAP_WIDTH-1:0]    cap_wd;
  logic                    res_we;
  logic [AW-1:0]           res_wa, res_ra;
  logic [RW-1:0]           res_wd;
  logic                    par_we;
  logic [VW-1:0]           par_wa, par_ra;

  // shared unit
  alu_op_t                 alu_op;
  logic [FW-1:0]           alu_a, alu_y;

  logic                    in_acc;
  logic [VW:0]             n_cur;
  logic [VW-1:0]           i_idx;
  logic [TW-1:0]           tot_ext;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_valid    = out_valid_r;
  assign out_max_flow = out_flow_r;
  assign i_idx = i_r[VW-1:0];
  assign n_cur = (int'(vcount_r) > MAX_VERTICES) ? (VW+1)'(MAX_VERTICES)
                                                 : (VW+1)'(vcount_r);
  assign tot_ext = TW'(total_r);

  // shared unit operand selection
  assign alu_a = (state_r == ST_ACC) ? total_r : FW'(res_q);
  always_comb begin
    unique case (state_r)
      ST_MINC: alu_op = ALU_MIN;
      ST_UPDF: alu_op = ALU_SUB;
      default: alu_op = ALU_ADD;
    endcase
  end

  mfda_alu #(.DW(FW)) u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (least_r),
    .y  (alu_y)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cp_v_nxt      = 1'b0;
    cp_a_nxt      = cnt_r[AW-1:0];
    visited_nxt   = visited_r;
    out_valid_nxt = out_valid_r;
    out_flow_nxt  = out_flow_r;
    n_nxt         = n_r;
    s_nxt         = s_r;
    t_nxt         = t_r;
    u_nxt         = u_r;
    i_nxt         = i_r;
    v_nxt         = v_r;
    p_nxt         = p_r;
    least_nxt     = least_r;
    total_nxt     = total_r;
    cap_we        = 1'b0;
    cap_wa        = cnt_r[AW-1:0];
    cap_wd        = '0;
    cap_ra        = cnt_r[AW-1:0];
    res_we        = 1'b0;
    res_wa        = cp_a_r;
    res_wd        = RW'(cap_q);
    res_ra        = {u_r, i_idx};
    par_we        = 1'b0;
    par_wa        = i_idx;
    par_ra        = u_r;

    // output register drains independently
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // copy pipeline tail writes the residual matrix
    if (cp_v_r) begin
      res_we = 1'b1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_operation)
            OP_LOAD: begin
              if (int'(in_row_vertex) < MAX_VERTICES &&
                  int'(in_col_vertex) < MAX_VERTICES) begin
                cap_we = 1'b1;
                cap_wa = {VW'(in_row_vertex), VW'(in_col_vertex)};
                cap_wd = CAP_WIDTH'(in_edge_capacity);
              end
            end
            OP_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = ST_CLR;
            end
            OP_RUN: begin
              n_nxt     = n_cur;
              s_nxt     = VW'(in_source_vertex);
              t_nxt     = VW'(in_sink_vertex);
              total_nxt = '0;
              cnt_nxt   = '0;
              if (int'(in_source_vertex) >= int'(n_cur) ||
                  int'(in_sink_vertex) >= int'(n_cur) ||
                  in_source_vertex == in_sink_vertex) begin
                state_nxt = ST_FIN;
              end else begin
                state_nxt = ST_COPY;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // zero sweep of the capacity matrix
      ST_CLR: begin
        cap_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[AW-1:0] == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      // capacity to residual copy, one entry a cycle
      ST_COPY: begin
        if (int'(cnt_r) < DEPTH) begin
          cp_v_nxt = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end else begin
          state_nxt = ST_SINIT;
        end
      end
      ST_SINIT: begin
        visited_nxt      = '0;
        visited_nxt[s_r] = 1'b1;
        u_nxt            = s_r;
        i_nxt            = '0;
        state_nxt        = ST_SCAN;
      end
      // probe next neighbor, backtrack to parent, or finish when the source is exhausted
      ST_SCAN: begin
        if (i_r >= n_r) begin
          if (u_r == s_r) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_POP;
          end
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (res_q != '0 && !visited_r[i_idx]) begin
          par_we             = 1'b1;
          visited_nxt[i_idx] = 1'b1;
          if (i_idx == t_r) begin
            least_nxt = '1;
            v_nxt     = t_r;
            state_nxt = ST_MINP;
          end else begin
            u_nxt     = i_idx;
            i_nxt     = '0;
            state_nxt = ST_SCAN;
          end
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      // resume the parent after the child just finished
      ST_POP: begin
        u_nxt     = par_q;
        i_nxt     = {1'b0, u_r} + 1'b1;
        state_nxt = ST_SCAN;
      end
      // bottleneck pass
      ST_MINP: begin
        par_ra    = v_r;
        state_nxt = ST_MINR;
      end
      ST_MINR: begin
        p_nxt     = par_q;
        res_ra    = {par_q, v_r};
        state_nxt = ST_MINC;
      end
      ST_MINC: begin
        least_nxt = alu_y;
        v_nxt     = p_r;
        if (p_r == s_r) begin
          v_nxt     = t_r;
          state_nxt = ST_UPDP;
        end else begin
          state_nxt = ST_MINP;
        end
      end
      // residual update pass
      ST_UPDP: begin
        par_ra    = v_r;
        state_nxt = ST_UPDR;
      end
      ST_UPDR: begin
        p_nxt     = par_q;
        res_ra    = {par_q, v_r};
        state_nxt = ST_UPDF;
      end
      ST_UPDF: begin
        res_we    = 1'b1;
        res_wa    = {p_r, v_r};
        res_wd    = RW'(alu_y);
        res_ra    = {v_r, p_r};
        state_nxt = ST_UPDB;
      end
      ST_UPDB: begin
        res_we = 1'b1;
        res_wa = {v_r, p_r};
        res_wd = RW'(alu_y);
        v_nxt  = p_r;
        if (p_r == s_r) begin
          state_nxt = ST_ACC;
        end else begin
          state_nxt = ST_UPDP;
        end
      end
      ST_ACC: begin
        total_nxt = alu_y;
        state_nxt = ST_SINIT;
      end
      // hand the total to the output register
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_flow_nxt  = (tot_ext > TW'(FLOW_MAX)) ? FLOW_MAX : FLOW_W'(tot_ext);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      cnt_r       <= '0;
      cp_v_r      <= 1'b0;
      visited_r   <= '0;
      out_valid_r <= 1'b0;
      vcount_r    <= 5'd16;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cp_v_r      <= cp_v_nxt;
      visited_r   <= visited_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        vcount_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cp_a_r     <= cp_a_nxt;
    n_r        <= n_nxt;
    s_r        <= s_nxt;
    t_r        <= t_nxt;
    u_r        <= u_nxt;
    i_r        <= i_nxt;
    v_r        <= v_nxt;
    p_r        <= p_nxt;
    least_r    <= least_nxt;
    total_r    <= total_nxt;
    out_flow_r <= out_flow_nxt;
  end

  // capacity matrix
  always_ff @(posedge clk) begin
    if (cap_we) begin
      cap_mem[cap_wa] <= cap_wd;
    end
    cap_q <= cap_mem[cap_ra];
  end

  // residual matrix
  always_ff @(posedge clk) begin
    if (res_we) begin
      res_mem[res_wa] <= res_wd;
    end
    res_q <= res_mem[res_ra];
  end

  // search tree parents
  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[par_wa] <= u_r;
    end
    par_q <= par_mem[par_ra];
  end

  `MFDA_ASSERT_NEXT(a_trivial_run, in_acc && in_operation == OP_RUN && in_source_vertex == in_sink_vertex, state_r == ST_FIN && total_r == '0, "equal endpoints must finish with zero flow")
  `MFDA_ASSERT_NOW(a_scan_visited, state_r == ST_SCAN, visited_r[u_r], "search frame on an unvisited vertex")
  `MFDA_ASSERT_NOW(a_least_nonzero, state_r == ST_UPDP, least_r != '0, "augmenting path with zero bottleneck")
  `MFDA_ASSERT_NOW(a_busy_no_ready, state_r != ST_IDLE, !in_ready, "input taken while a run or sweep is busy")

endmodule

[rtl/mfda_alu.sv]
// shared arithmetic unit: minimum, subtract, add
// depends on mfda_pkg
module mfda_alu
  import mfda_pkg::*;
#(
  parameter int DW = 21
) (
  input  alu_op_t         op,
  input  logic [DW-1:0]   a,
  input  logic [DW-1:0]   b,
  output logic [DW-1:0]   y
);

  // one compare, subtract or add per use
  always_comb begin
    unique case (op)
      ALU_MIN: y = (a < b) ? a : b;
      ALU_SUB: y = a - b;
      ALU_ADD: y = a + b;
      default: y = a;
    endcase
  end

endmodule

[bench/max_flow_checker.sv]
// checker for the max flow block: watches both channels, predicts each run result
// depends on mfda_pkg; instantiated beside the block by tb_max_flow_dfs_augment
`timescale 1ns / 1ps

module max_flow_checker
  import mfda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [3:0]  in_row_vertex,
  input  logic [3:0]  in_col_vertex,
  input  logic [15:0] in_edge_capacity,
  input  logic [3:0]  in_source_vertex,
  input  logic [3:0]  in_sink_vertex,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [19:0] out_max_flow,
  output int          fail_count,
  output int          flows_pending
);

  localparam int NV = 16;

  logic [15:0]  cap_mem [NV*NV];
  logic [4:0]   nodes_used;
  logic [19:0]  flow_queue [$];

  // depth-first search from s toward t; fills parent
  function automatic bit find_path(input int n, input int s, input int t,
                                   ref longint resid [NV*NV], ref int parent [NV]);
    int stk [NV];
    int nxt [NV];
    bit seen [NV];
    int depth;
    int u;
    int i;
    for (int k = 0; k < NV; k++) seen[k] = 0;
    seen[s] = 1;
    stk[0] = s;
    nxt[0] = 0;
    depth = 1;
    while (depth > 0) begin
      u = stk[depth-1];
      i = nxt[depth-1];
      if (i >= n) begin
        depth--;
        continue;
      end
      nxt[depth-1] = i + 1;
      if (resid[u*NV+i] != 0 && !seen[i]) begin
        parent[i] = u;
        seen[i] = 1;
        if (i == t) return 1;
        if (depth < NV) begin
          stk[depth] = i;
          nxt[depth] = 0;
          depth++;
        end
      end
    end
    return 0;
  endfunction

  function automatic logic [19:0] predict_flow(input int s, input int t);
    longint resid [NV*NV];
    int parent [NV];
    int n;
    longint total;
    longint least;
    int v;
    int p;
    n = (nodes_used > NV) ? NV : int'(nodes_used);
    total = 0;
    if (s >= n || t >= n || s == t) return '0;
    for (int k = 0; k < NV*NV; k++) resid[k] = cap_mem[k];
    while (find_path(n, s, t, resid, parent)) begin
      least = 64'h7fff_ffff_ffff;
      v = t;
      while (v != s) begin
        p = parent[v];
        if (resid[p*NV+v] < least) least = resid[p*NV+v];
        v = p;
      end
      v = t;
      while (v != s) begin
        p = parent[v];
        resid[p*NV+v] -= least;
        resid[v*NV+p] += least;
        v = p;
      end
      total += least;
    end
    return (total > FLOW_MAX) ? FLOW_MAX : total[19:0];
  endfunction

  assign flows_pending = flow_queue.size();

  // track configuration and input transactions, compare results
  always @(posedge clk) begin
    logic [19:0] want;
    if (!rst_n) begin
      for (int k = 0; k < NV*NV; k++) cap_mem[k] = '0;
      nodes_used = 5'd16;
      flow_queue.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (flow_queue.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual max_flow %0d",
                   $time, out_max_flow);
          fail_count++;
        end else begin
          want = flow_queue.pop_front();
          if (out_max_flow !== want) begin
            $display("%0t: max_flow mismatch, expected %0d, actual %0d",
                     $time, want, out_max_flow);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        case (in_operation)
          OP_LOAD:  cap_mem[in_row_vertex*NV+in_col_vertex] = in_edge_capacity;
          OP_CLEAR: for (int k = 0; k < NV*NV; k++) cap_mem[k] = '0;
          OP_RUN:   flow_queue.push_back(predict_flow(in_source_vertex, in_sink_vertex));
          default: ;
        endcase
      end
      if (cfg_wr_en) nodes_used = cfg_wr_data;
    end
  end

endmodule

[bench/tb_max_flow_dfs_augment.sv]
// testbench top for the max flow block: clock, reset, stimulus and verdict
// depends on mfda_pkg, max_flow_dfs_augment and max_flow_checker
`timescale 1ns / 1ps

module tb_max_flow_dfs_augment;
  import mfda_pkg::*;

  localparam logic [1:0] OP_BAD = 2'd3;
  localparam longint CYCLE_LIMIT = 64'd6000000;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [4:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_operation;
  logic [3:0]  in_row_vertex;
  logic [3:0]  in_col_vertex;
  logic [15:0] in_edge_capacity;
  logic [3:0]  in_source_vertex;
  logic [3:0]  in_sink_vertex;
  logic        out_valid;
  logic        out_ready;
  logic [19:0] out_max_flow;
  int          fail_count;
  int          flows_pending;
  longint      cycle_count;
  int          hold_requests;

  max_flow_dfs_augment dut (.*);

  max_flow_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // timeout watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int gap;
    int holds_taken;
    holds_taken = 0;
    out_ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_requests != holds_taken) begin
        holds_taken = hold_requests;
        out_ready <= 0;
        repeat (20000) @(posedge clk);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
    end
  end

  task automatic send(input logic [1:0] op, input logic [3:0] r, input logic [3:0] c,
                      input logic [15:0] cap, input logic [3:0] s, input logic [3:0] t,
                      input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1;
    in_operation     <= op;
    in_row_vertex    <= r;
    in_col_vertex    <= c;
    in_edge_capacity <= cap;
    in_source_vertex <= s;
    in_sink_vertex   <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (flows_pending != 0) @(posedge clk);
    // a trailing clear may still be sweeping
    repeat (300) @(posedge clk);
  endtask

  task automatic write_nodes(input logic [4:0] n);
    cfg_wr_en   <= 1;
    cfg_wr_data <= n;
    @(posedge clk);
    cfg_wr_en <= 0;
    @(posedge clk);
  endtask

  // random graph on n vertices followed by runs
  task automatic random_graph(input int n, input int edges);
    logic [15:0] cap;
    for (int k = 0; k < edges; k++) begin
      case ($urandom_range(0, 3))
        0: cap = 16'($urandom);
        1: cap = 16'($urandom_range(1, 15));
        2: cap = 16'hFFFF;
        default: cap = 16'($urandom_range(0, 300));
      endcase
      send(OP_LOAD, 4'($urandom_range(0, n - 1)), 4'($urandom_range(0, n - 1)), cap,
           0, 0, 0);
    end
    for (int k = 0; k < 3; k++)
      send(OP_RUN, 4'($urandom), 4'($urandom), 16'($urandom),
           4'($urandom_range(0, n - 1)), 4'($urandom_range(0, n - 1)), 0);
  endtask

  initial begin
    int n;
    rst_n = 0;
    cfg_wr_en = 0;
    cfg_wr_data = '0;
    in_valid = 0;
    in_operation = '0;
    in_row_vertex = '0;
    in_col_vertex = '0;
    in_edge_capacity = '0;
    in_source_vertex = '0;
    in_sink_vertex = '0;
    hold_requests = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: chain with a bottleneck, extremes, special cases
    send(OP_LOAD, 0, 1, 16'hFFFF, 0, 0, 0);
    send(OP_LOAD, 1, 15, 16'hFFFF, 0, 0, 0);
    send(OP_LOAD, 0, 15, 16'hFFFF, 0, 0, 0);
    send(OP_LOAD, 15, 0, 16'd1, 0, 0, 0);
    send(OP_RUN, 0, 0, 0, 0, 15, 0);
    send(OP_RUN, 0, 0, 0, 15, 0, 0);
    send(OP_RUN, 0, 0, 0, 5, 5, 0);
    send(OP_BAD, 4'hF, 4'hF, 16'hFFFF, 4'hF, 4'hF, 0);
    // many parallel full edges: a large flow, still below the saturation value
    for (int k = 2; k < 15; k++) begin
      send(OP_LOAD, 0, 4'(k), 16'hFFFF, 0, 0, 0);
      send(OP_LOAD, 4'(k), 15, 16'hFFFF, 0, 0, 0);
    end
    send(OP_RUN, 0, 0, 0, 0, 15, 0);
    drain();
    write_nodes(5'd2);
    send(OP_RUN, 0, 0, 0, 0, 1, 0);
    send(OP_RUN, 0, 0, 0, 0, 15, 0);
    drain();
    write_nodes(5'd31);
    send(OP_RUN, 0, 0, 0, 0, 15, 0);
    send(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    send(OP_RUN, 0, 0, 0, 0, 15, 0);
    drain();

    // long receiver hold while later transactions wait behind a held result
    hold_requests = hold_requests + 1;
    write_nodes(5'd16);
    random_graph(16, 20);
    drain();

    // random phases across vertex counts
    for (int ph = 0; ph < 20; ph++) begin
      case (ph % 5)
        0: n = 2;
        1: n = 16;
        default: n = $urandom_range(3, 8);
      endcase
      write_nodes(5'(n));
      if ($urandom_range(0, 2) == 0) send(OP_CLEAR, 4'($urandom), 4'($urandom),
                                          16'($urandom), 4'($urandom), 4'($urandom), 0);
      for (int g = 0; g < 4; g++) begin
        if ($urandom_range(0, 9) == 0)
          send(2'($urandom_range(0, 3)), 4'($urandom), 4'($urandom), 16'($urandom),
               4'($urandom), 4'($urandom), 0);
        random_graph(n, $urandom_range(1, 3 * n));
      end
      drain();
    end
    repeat (50) @(posedge clk);
    if (fail_count == 0 && flows_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
